### design/sdz_pkg.sv
// shared constants for the radial dead zone pipeline
package sdz_pkg;

    // default sample width, signed Q1.(SAMPLE_BITS-1)
    localparam int SAMPLE_BITS_DEF = 16;

    // square root radicand and root widths (magnitude in Q.31)
    localparam int RAD_BITS  = 64;
    localparam int ROOT_BITS = RAD_BITS / 2;

    // dead zone radius register, unsigned Q0.15
    localparam int DR_BITS = 15;

    // configuration register map
    localparam int ADDR_BITS = 1;
    localparam logic [ADDR_BITS-1:0] ADDR_DEAD_RADIUS = 1'b0;

endpackage

### design/sdz_sqrt.sv
// pipelined integer square root, one root bit per stage
module sdz_sqrt #(
    parameter int RAD_BITS  = sdz_pkg::RAD_BITS,
    parameter int SIDE_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [RAD_BITS-1:0]       rad,
    input  logic [SIDE_BITS-1:0]      side,
    output logic                      out_valid,
    output logic [RAD_BITS/2-1:0]     root,
    output logic [SIDE_BITS-1:0]      out_side
);

    localparam int STEPS = RAD_BITS / 2;
    localparam int RB    = STEPS;

    logic [RAD_BITS-1:0]  rad_reg  [STEPS];
    logic [RB:0]          rem_reg  [STEPS];
    logic [RB-1:0]        root_reg [STEPS];
    logic [SIDE_BITS-1:0] side_reg [STEPS];
    logic [STEPS-1:0]     valid_reg;

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            logic [RAD_BITS-1:0]  rad_in;
            logic [RB:0]          rem_in;
            logic [RB-1:0]        root_in;
            logic [SIDE_BITS-1:0] side_in;
            logic                 v_in;
            logic [RB+2:0]        rem_sh;
            logic [RB+2:0]        trial;
            logic [RB+2:0]        diff;
            logic                 ge;
            logic [RB:0]          rem_next;
            logic [RB-1:0]        root_next;

            // stage inputs
            if (k == 0)
            begin : g_first
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
                assign side_in = side;
                assign v_in    = in_valid;
            end
            else
            begin : g_next
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign side_in = side_reg[k-1];
                assign v_in    = valid_reg[k-1];
            end

            // one restoring step on the next bit pair
            assign rem_sh    = {rem_in, rad_in[RAD_BITS-1 -: 2]};
            assign trial     = {1'b0, root_in, 2'b01};
            assign diff      = rem_sh - trial;
            assign ge        = (rem_sh >= trial);
            assign rem_next  = ge ? diff[RB:0] : rem_sh[RB:0];
            assign root_next = {root_in[RB-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= rad_in << 2;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

### design/sdz_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module sdz_div #(
    parameter int NUM_BITS  = 64,
    parameter int DEN_BITS  = 48,
    parameter int Q_BITS    = 17,
    parameter int SIDE_BITS = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUM_BITS-1:0]  num,
    input  logic [DEN_BITS-1:0]  den,
    input  logic [SIDE_BITS-1:0] side,
    output logic                 out_valid,
    output logic [Q_BITS-1:0]    quo,
    output logic                 over,
    output logic [SIDE_BITS-1:0] out_side
);

    localparam int HI_BITS = NUM_BITS - Q_BITS;
    localparam int CMP_BITS = (HI_BITS > DEN_BITS) ? HI_BITS : DEN_BITS;

    logic [DEN_BITS-1:0]  rem_reg  [Q_BITS+1];
    logic [Q_BITS-1:0]    low_reg  [Q_BITS+1];
    logic [Q_BITS-1:0]    q_reg    [Q_BITS+1];
    logic [DEN_BITS-1:0]  den_reg  [Q_BITS+1];
    logic                 over_reg [Q_BITS+1];
    logic [SIDE_BITS-1:0] side_reg [Q_BITS+1];
    logic [Q_BITS:0]      valid_reg;

    // first stage: quotient beyond Q_BITS means overflow
    logic over_next;
    assign over_next = (CMP_BITS'(num[NUM_BITS-1:Q_BITS]) >= CMP_BITS'(den));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_BITS'(num[NUM_BITS-1:Q_BITS]);
            low_reg[0]  <= num[Q_BITS-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            over_reg[0] <= over_next;
            side_reg[0] <= side;
        end
    end

    genvar j;
    generate
        for (j = 1; j <= Q_BITS; j++)
        begin : g_step
            logic [DEN_BITS:0]   rem_sh;
            logic [DEN_BITS:0]   diff;
            logic                ge;
            logic [DEN_BITS-1:0] rem_next;

            // shift in one dividend bit and try a subtract
            assign rem_sh   = {rem_reg[j-1], low_reg[j-1][Q_BITS-1]};
            assign diff     = rem_sh - {1'b0, den_reg[j-1]};
            assign ge       = (rem_sh >= {1'b0, den_reg[j-1]});
            assign rem_next = ge ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j]  <= rem_next;
                    low_reg[j]  <= low_reg[j-1] << 1;
                    q_reg[j]    <= {q_reg[j-1][Q_BITS-2:0], ge};
                    den_reg[j]  <= den_reg[j-1];
                    over_reg[j] <= over_reg[j-1];
                    side_reg[j] <= side_reg[j-1];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[Q_BITS];
    assign quo       = q_reg[Q_BITS];
    assign over      = over_reg[Q_BITS];
    assign out_side  = side_reg[Q_BITS];

endmodule

### design/stick_radial_deadzone_core.sv
// top level: radial scaled dead zone for one analog stick
// Takes one stick word per cycle (X, Y in signed Q1.(SAMPLE_BITS-1)) and returns one word with
// the direction scaled by (mag - dead)/(1 - dead), saturated, plus an inside_dead flag. The core
// is a fully pipelined datapath that accepts a word every cycle unless the output stalls; its depth
// comes from the one-bit-per-stage square root and the one-bit-per-stage rounding dividers. A
// stalled output freezes the whole pipeline. dead_radius (Q0.15, byte address 0) must only be
// written while no words are in flight.
module stick_radial_deadzone_core #(
    parameter int SAMPLE_BITS = sdz_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // config port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [sdz_pkg::ADDR_BITS-1:0]           paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // stick_x, stick_y
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // output stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // dir_x, dir_y, inside_dead
    output logic [((2*SAMPLE_BITS+8)/8)*8-1:0]      m_tdata
);

    localparam int SB       = SAMPLE_BITS;
    localparam int F        = SB - 1;
    localparam int SHIFT    = 62 - 2 * F;
    localparam int RB       = sdz_pkg::ROOT_BITS;
    localparam int DRB      = sdz_pkg::DR_BITS;
    localparam int SC_BITS  = DRB + 1;
    localparam int P_BITS   = SB + RB;
    localparam int DEN_BITS = RB + SC_BITS;
    localparam int NUM_BITS = P_BITS + 16;
    localparam int Q_BITS   = SB + 1;
    localparam int SIDE_SQ  = 2 * SB + 2;
    localparam int OUT_W    = ((2 * SB + 8) / 8) * 8;

    // config register
    logic [DRB-1:0] dead_radius_reg;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == sdz_pkg::ADDR_DEAD_RADIUS);
    assign prdata = (paddr == sdz_pkg::ADDR_DEAD_RADIUS) ? 32'(dead_radius_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_radius_reg <= '0;
        end
        else if (cfg_wr)
        begin
            dead_radius_reg <= pwdata[DRB-1:0];
        end
    end

    // global advance: the pipeline moves whenever the output slot is free
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // stage 1: magnitudes and squares
    logic signed [SB-1:0] x_in;
    logic signed [SB-1:0] y_in;
    logic [SB-1:0]        ax_next;
    logic [SB-1:0]        ay_next;
    assign x_in    = s_tdata[SB-1:0];
    assign y_in    = s_tdata[2*SB-1:SB];
    assign ax_next = x_in[SB-1] ? SB'(-x_in) : SB'(x_in);
    assign ay_next = y_in[SB-1] ? SB'(-y_in) : SB'(y_in);

    logic              v1_reg;
    logic [SB-1:0]     ax1_reg, ay1_reg;
    logic              sx1_reg, sy1_reg;
    logic [2*SB-1:0]   sqx1_reg, sqy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg  <= ax_next;
            ay1_reg  <= ay_next;
            sx1_reg  <= x_in[SB-1];
            sy1_reg  <= y_in[SB-1];
            sqx1_reg <= ax_next * ax_next;
            sqy1_reg <= ay_next * ay_next;
        end
    end

    // stage 2: sum of squares
    logic              v2_reg;
    logic [2*SB-1:0]   sum2_reg;
    logic [SIDE_SQ-1:0] side2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum2_reg  <= sqx1_reg + sqy1_reg;
            side2_reg <= {sy1_reg, sx1_reg, ay1_reg, ax1_reg};
        end
    end

    // magnitude in Q.31
    logic [sdz_pkg::RAD_BITS-1:0] rad;
    logic                         vs;
    logic [RB-1:0]                mag;
    logic [SIDE_SQ-1:0]           side_s;
    assign rad = sdz_pkg::RAD_BITS'(sum2_reg) << SHIFT;

    sdz_sqrt #(
        .RAD_BITS  (sdz_pkg::RAD_BITS),
        .SIDE_BITS (SIDE_SQ)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .rad       (rad),
        .side      (side2_reg),
        .out_valid (vs),
        .root      (mag),
        .out_side  (side_s)
    );

    // stage 3: dead zone compare and offsets
    logic [RB-1:0]      dead_q31;
    assign dead_q31 = RB'({dead_radius_reg, 16'd0});

    logic               v3_reg;
    logic [RB-1:0]      m3_reg, diff3_reg;
    logic [SC_BITS-1:0] sc3_reg;
    logic               below3_reg, zero3_reg;
    logic [SIDE_SQ-1:0] side3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= vs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_reg     <= mag;
            diff3_reg  <= mag - dead_q31;
            sc3_reg    <= SC_BITS'(1 << DRB) - SC_BITS'(dead_radius_reg);
            below3_reg <= (mag < dead_q31);
            zero3_reg  <= (mag == '0);
            side3_reg  <= side_s;
        end
    end

    // stage 4: products
    logic               v4_reg;
    logic [P_BITS-1:0]  px4_reg, py4_reg;
    logic [DEN_BITS-1:0] den4_reg;
    logic               below4_reg, zero4_reg, sx4_reg, sy4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px4_reg    <= side3_reg[SB-1:0] * diff3_reg;
            py4_reg    <= side3_reg[2*SB-1:SB] * diff3_reg;
            den4_reg   <= m3_reg * sc3_reg;
            below4_reg <= below3_reg;
            zero4_reg  <= zero3_reg;
            sx4_reg    <= side3_reg[2*SB];
            sy4_reg    <= side3_reg[2*SB+1];
        end
    end

    // stage 5: scaled numerators with half divisor for rounding
    logic                v5_reg;
    logic [NUM_BITS-1:0] nx5_reg, ny5_reg;
    logic [DEN_BITS-1:0] den5_reg;
    logic [2:0]          flags5_reg;
    logic                sy5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx5_reg    <= (NUM_BITS'(px4_reg) << 15) + NUM_BITS'(den4_reg >> 1);
            ny5_reg    <= (NUM_BITS'(py4_reg) << 15) + NUM_BITS'(den4_reg >> 1);
            den5_reg   <= den4_reg;
            flags5_reg <= {zero4_reg, below4_reg, sx4_reg};
            sy5_reg    <= sy4_reg;
        end
    end

    // rounding dividers, one per component
    logic              vqx, vqy;
    logic [Q_BITS-1:0] qx, qy;
    logic              ovx, ovy;
    logic [2:0]        flags_q;
    logic              sy_q;

    sdz_div #(
        .NUM_BITS  (NUM_BITS),
        .DEN_BITS  (DEN_BITS),
        .Q_BITS    (Q_BITS),
        .SIDE_BITS (3)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .num       (nx5_reg),
        .den       (den5_reg),
        .side      (flags5_reg),
        .out_valid (vqx),
        .quo       (qx),
        .over      (ovx),
        .out_side  (flags_q)
    );

    sdz_div #(
        .NUM_BITS  (NUM_BITS),
        .DEN_BITS  (DEN_BITS),
        .Q_BITS    (Q_BITS),
        .SIDE_BITS (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .num       (ny5_reg),
        .den       (den5_reg),
        .side      (sy5_reg),
        .out_valid (vqy),
        .quo       (qy),
        .over      (ovy),
        .out_side  (sy_q)
    );

    // saturate and restore sign
    logic              zero_q, below_q, sx_q;
    logic [Q_BITS-1:0] lim_x, lim_y, satx, saty, negx, negy;
    logic [SB-1:0]     dir_x_next, dir_y_next;
    assign {zero_q, below_q, sx_q} = flags_q;
    assign lim_x = (Q_BITS'(1) << F) - Q_BITS'(!sx_q);
    assign lim_y = (Q_BITS'(1) << F) - Q_BITS'(!sy_q);
    assign satx  = (ovx || (qx > lim_x)) ? lim_x : qx;
    assign saty  = (ovy || (qy > lim_y)) ? lim_y : qy;
    assign negx  = -satx;
    assign negy  = -saty;
    assign dir_x_next = (zero_q || below_q) ? '0 : (sx_q ? negx[SB-1:0] : satx[SB-1:0]);
    assign dir_y_next = (zero_q || below_q) ? '0 : (sy_q ? negy[SB-1:0] : saty[SB-1:0]);

    // output register
    logic [SB-1:0] dir_x_reg, dir_y_reg;
    logic          inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vqx && vqy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir_x_reg  <= dir_x_next;
            dir_y_reg  <= dir_y_next;
            inside_reg <= below_q;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({inside_reg, dir_y_reg, dir_x_reg});

`ifndef SYNTHESIS
    // a word inside the dead zone carries a zero direction
    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && inside_reg) |-> (dir_x_reg == '0 && dir_y_reg == '0))
        else $error("dead zone word with nonzero direction");

    // a held output word freezes the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted during output stall");

    // magnitude below radius needs a nonzero radius
    a_below: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && below3_reg) |-> (dead_radius_reg != '0))
        else $error("below dead zone with zero radius");

    // both component dividers stay in lockstep
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        vqx == vqy)
        else $error("component dividers out of step");
`endif

endmodule
